[src/led_text_scroller_unit_assert.svh]
// ---------------------------------------------------------------------------
// led_text_scroller_unit_assert.svh
// assertion macros shared by the scroller rtl
// ---------------------------------------------------------------------------
`ifndef LED_TEXT_SCROLLER_UNIT_ASSERT_SVH
`define LED_TEXT_SCROLLER_UNIT_ASSERT_SVH

// same-cycle implication, sampled on clk, off during rst
`define LTS_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on clk, off during rst
`define LTS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[src/lts_pkg.sv]
// ---------------------------------------------------------------------------
// lts_pkg
// constants, types and the 5x7 font table of the led text scroller
// ---------------------------------------------------------------------------
package lts_pkg;

  localparam int NUM_ROWS   = 7;   // row shift registers
  localparam int GLYPH_ROWS = 7;   // rows that take glyph data
  localparam int ROW_BITS   = 40;  // bits per row shift register
  localparam int WIN_LSB    = 8;   // lowest bit of the visible window
  localparam int WIN_BITS   = ROW_BITS - WIN_LSB;
  localparam int FONT_DEPTH = 96;
  localparam int IDX_BITS   = $clog2(FONT_DEPTH);
  localparam int MAX_WIDTH  = 6;
  localparam int WIDTH_BITS = $clog2(MAX_WIDTH + 1);

  localparam logic [7:0] FIRST_CODE = 8'h20;
  localparam logic [7:0] LAST_CODE  = 8'h7f;

  typedef logic [ROW_BITS-1:0]   row_t;
  typedef logic [IDX_BITS-1:0]   glyph_idx_t;
  typedef logic [WIDTH_BITS-1:0] width_t;

  typedef struct packed {
    logic [NUM_ROWS-1:0][7:0] rows;   // rows[0] is the top row
    width_t                   width;  // columns including spacing
  } glyph_t;

  function automatic glyph_t mk(input logic [7:0] r0, input logic [7:0] r1,
                                input logic [7:0] r2, input logic [7:0] r3,
                                input logic [7:0] r4, input logic [7:0] r5,
                                input logic [7:0] r6, input logic [7:0] w);
    glyph_t g;
    g.rows[0] = r0;
    g.rows[1] = r1;
    g.rows[2] = r2;
    g.rows[3] = r3;
    g.rows[4] = r4;
    g.rows[5] = r5;
    g.rows[6] = r6;
    g.width   = (w > 8'(MAX_WIDTH)) ? width_t'(MAX_WIDTH) : w[WIDTH_BITS-1:0];
    return g;
  endfunction

  // font table, index is code - 0x20
  function automatic glyph_t font_glyph(input glyph_idx_t idx);
    glyph_t g;
    unique case (idx)
      7'd0:  g = mk(8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'd6);
      7'd1:  g = mk(8'h80,8'h80,8'h80,8'h80,8'h00,8'h00,8'h80,8'd2);
      7'd2:  g = mk(8'hA0,8'hA0,8'hA0,8'h00,8'h00,8'h00,8'h00,8'd4);
      7'd3:  g = mk(8'h50,8'h50,8'hF8,8'h50,8'hF8,8'h50,8'h50,8'd6);
      7'd4:  g = mk(8'h20,8'h78,8'hA0,8'h70,8'h28,8'hF0,8'h20,8'd6);
      7'd5:  g = mk(8'hC0,8'hC8,8'h10,8'h20,8'h40,8'h98,8'h18,8'd6);
      7'd6:  g = mk(8'h60,8'h90,8'hA0,8'h40,8'hA8,8'h90,8'h68,8'd6);
      7'd7:  g = mk(8'hC0,8'h40,8'h80,8'h00,8'h00,8'h00,8'h00,8'd3);
      7'd8:  g = mk(8'h20,8'h40,8'h80,8'h80,8'h80,8'h40,8'h20,8'd4);
      7'd9:  g = mk(8'h80,8'h40,8'h20,8'h20,8'h20,8'h40,8'h80,8'd4);
      7'd10: g = mk(8'h00,8'h20,8'hA8,8'h70,8'hA8,8'h20,8'h00,8'd6);
      7'd11: g = mk(8'h00,8'h20,8'h20,8'hF8,8'h20,8'h20,8'h00,8'd6);
      7'd12: g = mk(8'h00,8'h00,8'h00,8'h00,8'hC0,8'h40,8'h80,8'd3);
      7'd13: g = mk(8'h00,8'h00,8'hF8,8'h00,8'h00,8'h00,8'h00,8'd6);
      7'd14: g = mk(8'h00,8'h00,8'h00,8'h00,8'h00,8'hC0,8'hC0,8'd3);
      7'd15: g = mk(8'h00,8'h08,8'h10,8'h20,8'h40,8'h80,8'h00,8'd6);
      7'd16: g = mk(8'h70,8'h88,8'h98,8'hA8,8'hC8,8'h88,8'h70,8'd6);
      7'd17: g = mk(8'h40,8'hC0,8'h40,8'h40,8'h40,8'h40,8'hE0,8'd4);
      7'd18: g = mk(8'h70,8'h88,8'h08,8'h10,8'h20,8'h40,8'hF8,8'd6);
      7'd19: g = mk(8'hF8,8'h10,8'h20,8'h10,8'h08,8'h88,8'h70,8'd6);
      7'd20: g = mk(8'h10,8'h30,8'h50,8'h90,8'hF8,8'h10,8'h10,8'd6);
      7'd21: g = mk(8'hF8,8'h80,8'hF0,8'h08,8'h08,8'h88,8'h70,8'd6);
      7'd22: g = mk(8'h30,8'h40,8'h80,8'hF0,8'h88,8'h88,8'h70,8'd6);
      7'd23: g = mk(8'hF8,8'h88,8'h08,8'h10,8'h20,8'h20,8'h20,8'd6);
      7'd24: g = mk(8'h70,8'h88,8'h88,8'h70,8'h88,8'h88,8'h70,8'd6);
      7'd25: g = mk(8'h70,8'h88,8'h88,8'h78,8'h08,8'h10,8'h60,8'd6);
      7'd26: g = mk(8'h00,8'hC0,8'hC0,8'h00,8'hC0,8'hC0,8'h00,8'd3);
      7'd27: g = mk(8'h00,8'hC0,8'hC0,8'h00,8'hC0,8'h40,8'h80,8'd3);
      7'd28: g = mk(8'h10,8'h20,8'h40,8'h80,8'h40,8'h20,8'h10,8'd5);
      7'd29: g = mk(8'h00,8'h00,8'hF8,8'h00,8'hF8,8'h00,8'h00,8'd6);
      7'd30: g = mk(8'h80,8'h40,8'h20,8'h10,8'h20,8'h40,8'h80,8'd5);
      7'd31: g = mk(8'h70,8'h88,8'h08,8'h10,8'h20,8'h00,8'h20,8'd6);
      7'd32: g = mk(8'h70,8'h88,8'h08,8'h68,8'hA8,8'hA8,8'h70,8'd6);
      7'd33: g = mk(8'h70,8'h88,8'h88,8'h88,8'hF8,8'h88,8'h88,8'd6);
      7'd34: g = mk(8'hF0,8'h88,8'h88,8'hF0,8'h88,8'h88,8'hF0,8'd6);
      7'd35: g = mk(8'h70,8'h88,8'h80,8'h80,8'h80,8'h88,8'h70,8'd6);
      7'd36: g = mk(8'hE0,8'h90,8'h88,8'h88,8'h88,8'h90,8'hE0,8'd6);
      7'd37: g = mk(8'hF8,8'h80,8'h80,8'hF0,8'h80,8'h80,8'hF8,8'd6);
      7'd38: g = mk(8'hF8,8'h80,8'h80,8'hF0,8'h80,8'h80,8'h80,8'd6);
      7'd39: g = mk(8'h70,8'h88,8'h80,8'hB8,8'h88,8'h88,8'h78,8'd6);
      7'd40: g = mk(8'h88,8'h88,8'h88,8'hF8,8'h88,8'h88,8'h88,8'd6);
      7'd41: g = mk(8'hE0,8'h40,8'h40,8'h40,8'h40,8'h40,8'hE0,8'd4);
      7'd42: g = mk(8'h38,8'h10,8'h10,8'h10,8'h10,8'h90,8'h60,8'd6);
      7'd43: g = mk(8'h88,8'h90,8'hA0,8'hC0,8'hA0,8'h90,8'h88,8'd6);
      7'd44: g = mk(8'h80,8'h80,8'h80,8'h80,8'h80,8'h80,8'hF8,8'd6);
      7'd45: g = mk(8'h88,8'hD8,8'hA8,8'hA8,8'h88,8'h88,8'h88,8'd6);
      7'd46: g = mk(8'h88,8'h88,8'hC8,8'hA8,8'h98,8'h88,8'h88,8'd6);
      7'd47: g = mk(8'h70,8'h88,8'h88,8'h88,8'h88,8'h88,8'h70,8'd6);
      7'd48: g = mk(8'hF0,8'h88,8'h88,8'hF0,8'h80,8'h80,8'h80,8'd6);
      7'd49: g = mk(8'h70,8'h88,8'h88,8'h88,8'hA8,8'h90,8'h68,8'd6);
      7'd50: g = mk(8'hF0,8'h88,8'h88,8'hF0,8'hA0,8'h90,8'h88,8'd6);
      7'd51: g = mk(8'h78,8'h80,8'h80,8'h70,8'h08,8'h08,8'hF0,8'd6);
      7'd52: g = mk(8'hF8,8'h20,8'h20,8'h20,8'h20,8'h20,8'h20,8'd6);
      7'd53: g = mk(8'h88,8'h88,8'h88,8'h88,8'h88,8'h88,8'h70,8'd6);
      7'd54: g = mk(8'h88,8'h88,8'h88,8'h88,8'h88,8'h50,8'h20,8'd6);
      7'd55: g = mk(8'h88,8'h88,8'h88,8'hA8,8'hA8,8'hA8,8'h50,8'd6);
      7'd56: g = mk(8'h88,8'h88,8'h50,8'h20,8'h50,8'h88,8'h88,8'd6);
      7'd57: g = mk(8'h88,8'h88,8'h88,8'h50,8'h20,8'h20,8'h20,8'd6);
      7'd58: g = mk(8'hF8,8'h08,8'h10,8'h20,8'h40,8'h80,8'hF8,8'd6);
      7'd59: g = mk(8'hE0,8'h80,8'h80,8'h80,8'h80,8'h80,8'hE0,8'd4);
      7'd60: g = mk(8'h00,8'h80,8'h40,8'h20,8'h10,8'h08,8'h00,8'd6);
      7'd61: g = mk(8'hE0,8'h20,8'h20,8'h20,8'h20,8'h20,8'hE0,8'd4);
      7'd62: g = mk(8'h20,8'h50,8'h88,8'h00,8'h00,8'h00,8'h00,8'd6);
      7'd63: g = mk(8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'hF8,8'd6);
      7'd64: g = mk(8'h80,8'h40,8'h20,8'h00,8'h00,8'h00,8'h00,8'd4);
      7'd65: g = mk(8'h00,8'h00,8'h70,8'h08,8'h78,8'h88,8'h78,8'd6);
      7'd66: g = mk(8'h80,8'h80,8'hB0,8'hC8,8'h88,8'h88,8'hF0,8'd6);
      7'd67: g = mk(8'h00,8'h00,8'h70,8'h88,8'h80,8'h88,8'h70,8'd6);
      7'd68: g = mk(8'h08,8'h08,8'h68,8'h98,8'h88,8'h88,8'h78,8'd6);
      7'd69: g = mk(8'h00,8'h00,8'h70,8'h88,8'hF8,8'h80,8'h70,8'd6);
      7'd70: g = mk(8'h30,8'h48,8'h40,8'hE0,8'h40,8'h40,8'h40,8'd6);
      7'd71: g = mk(8'h00,8'h78,8'h88,8'h88,8'h78,8'h08,8'h70,8'd6);
      7'd72: g = mk(8'h80,8'h80,8'hB0,8'hC8,8'h88,8'h88,8'h88,8'd6);
      7'd73: g = mk(8'h40,8'h00,8'hC0,8'h40,8'h40,8'h40,8'hE0,8'd4);
      7'd74: g = mk(8'h10,8'h00,8'h30,8'h10,8'h10,8'h90,8'h60,8'd5);
      7'd75: g = mk(8'h80,8'h80,8'h90,8'hA0,8'hC0,8'hA0,8'h90,8'd5);
      7'd76: g = mk(8'hC0,8'h40,8'h40,8'h40,8'h40,8'h40,8'hE0,8'd4);
      7'd77: g = mk(8'h00,8'h00,8'hD0,8'hA8,8'hA8,8'h88,8'h88,8'd6);
      7'd78: g = mk(8'h00,8'h00,8'hB0,8'hC8,8'h88,8'h88,8'h88,8'd6);
      7'd79: g = mk(8'h00,8'h00,8'h70,8'h88,8'h88,8'h88,8'h70,8'd6);
      7'd80: g = mk(8'h00,8'h00,8'hF0,8'h88,8'hF0,8'h80,8'h80,8'd6);
      7'd81: g = mk(8'h00,8'h00,8'h68,8'h98,8'h78,8'h08,8'h08,8'd6);
      7'd82: g = mk(8'h00,8'h00,8'hB0,8'hC8,8'h80,8'h80,8'h80,8'd6);
      7'd83: g = mk(8'h00,8'h00,8'h70,8'h80,8'h70,8'h08,8'hF0,8'd6);
      7'd84: g = mk(8'h40,8'h40,8'hE0,8'h40,8'h40,8'h48,8'h30,8'd6);
      7'd85: g = mk(8'h00,8'h00,8'h88,8'h88,8'h88,8'h98,8'h68,8'd6);
      7'd86: g = mk(8'h00,8'h00,8'h88,8'h88,8'h88,8'h50,8'h20,8'd6);
      7'd87: g = mk(8'h00,8'h00,8'h88,8'hA8,8'hA8,8'hA8,8'h50,8'd6);
      7'd88: g = mk(8'h00,8'h00,8'h88,8'h50,8'h20,8'h50,8'h88,8'd6);
      7'd89: g = mk(8'h00,8'h00,8'h88,8'h88,8'h78,8'h08,8'h70,8'd6);
      7'd90: g = mk(8'h00,8'h00,8'hF8,8'h10,8'h20,8'h40,8'hF8,8'd6);
      7'd91: g = mk(8'h20,8'h40,8'h40,8'h80,8'h40,8'h40,8'h20,8'd4);
      7'd92: g = mk(8'h80,8'h80,8'h80,8'h80,8'h80,8'h80,8'h80,8'd2);
      7'd93: g = mk(8'h80,8'h40,8'h40,8'h20,8'h40,8'h40,8'h80,8'd4);
      7'd94: g = mk(8'h00,8'h00,8'h00,8'h68,8'h90,8'h00,8'h00,8'd6);
      7'd95: g = mk(8'h60,8'h90,8'h90,8'h60,8'h00,8'h00,8'h00,8'd5);
      default: g = '0;
    endcase
    return g;
  endfunction

endpackage

[src/led_text_scroller_unit.sv]
// ---------------------------------------------------------------------------
// led_text_scroller_unit
// scrolling 5x7 text marquee for a 32x7 pixel window (four 8x8 matrices)
// ---------------------------------------------------------------------------
// Each item on the char channel is one character code. Codes 0x20..0x7f are
// drawn: the glyph's seven row bytes are ORed into the low byte of seven
// 40-bit row shift registers, then all rows shift left one column at a time,
// once per glyph column (2 to 6), and each shift gives one item on the pix
// channel with the visible window (bits 39..8 of each row) and last_step set
// on the final column. Other codes are dropped with no output. A drawn
// character goes in steps: the code is taken, the font table is read and
// the glyph merged, then each column goes through the single shared shift
// step when the output slot is free. A dropped code leaves the block idle.
// The char side is stalled while a character is in progress; the last
// column waits in the output register while the next code is taken.
// ---------------------------------------------------------------------------
`include "led_text_scroller_unit_assert.svh"

module led_text_scroller_unit #(
  parameter int GLYPH_ROWS = lts_pkg::GLYPH_ROWS  // rows that take glyph data
) (
  input  logic        clk,
  input  logic        rst,
  // char channel
  input  logic        char_valid,
  output logic        char_stall,
  input  logic [7:0]  char_code,
  // pix channel
  output logic        pix_valid,
  input  logic        pix_stall,
  output logic [31:0] row0_pixels,
  output logic [31:0] row1_pixels,
  output logic [31:0] row2_pixels,
  output logic [31:0] row3_pixels,
  output logic [31:0] row4_pixels,
  output logic [31:0] row5_pixels,
  output logic [31:0] row6_pixels,
  output logic        last_step
);

  typedef enum logic [1:0] {
    ST_IDLE,   // waiting for a code
    ST_LOAD,   // font read and glyph merge
    ST_SHIFT   // one column per free output slot
  } state_t;

  state_t                        state;
  lts_pkg::row_t                 rows [lts_pkg::NUM_ROWS];
  lts_pkg::glyph_idx_t           glyph_idx;
  lts_pkg::width_t               cols_left;   // shifts still to do
  lts_pkg::glyph_t               glyph;

  logic char_take;
  logic code_ok;
  logic slot_free;                            // output register can take a new column
  logic shift_go;                             // a column is shifted this cycle

  assign char_stall = (state != ST_IDLE);
  assign char_take  = char_valid && !char_stall;
  assign code_ok    = (char_code >= lts_pkg::FIRST_CODE) && (char_code <= lts_pkg::LAST_CODE);
  assign slot_free  = !pix_valid || !pix_stall;
  assign shift_go   = (state == ST_SHIFT) && slot_free;

  // font table lookup from the latched index
  assign glyph = lts_pkg::font_glyph(glyph_idx);

  // the window is the top 32 bits of each row register; a glyph merge only
  // touches the low byte and no shift runs while an item waits, so it never moves
  assign row0_pixels = rows[0][lts_pkg::ROW_BITS-1:lts_pkg::WIN_LSB];
  assign row1_pixels = rows[1][lts_pkg::ROW_BITS-1:lts_pkg::WIN_LSB];
  assign row2_pixels = rows[2][lts_pkg::ROW_BITS-1:lts_pkg::WIN_LSB];
  assign row3_pixels = rows[3][lts_pkg::ROW_BITS-1:lts_pkg::WIN_LSB];
  assign row4_pixels = rows[4][lts_pkg::ROW_BITS-1:lts_pkg::WIN_LSB];
  assign row5_pixels = rows[5][lts_pkg::ROW_BITS-1:lts_pkg::WIN_LSB];
  assign row6_pixels = rows[6][lts_pkg::ROW_BITS-1:lts_pkg::WIN_LSB];

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      pix_valid <= 1'b0;
      last_step <= 1'b0;
      cols_left <= '0;
      for (int r = 0; r < lts_pkg::NUM_ROWS; r++) begin
        rows[r] <= '0;
      end
    end else begin
      // a new shift refills the output slot, else it drains when taken
      if (shift_go) begin
        pix_valid <= 1'b1;
      end else if (pix_valid && !pix_stall) begin
        pix_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (char_take && code_ok) begin
            // code - 0x20, low bits are enough inside the drawn range
            glyph_idx <= lts_pkg::glyph_idx_t'(char_code - lts_pkg::FIRST_CODE);
            state     <= ST_LOAD;
          end
        end
        ST_LOAD: begin
          // merge into the hidden low byte only
          for (int r = 0; r < lts_pkg::NUM_ROWS; r++) begin
            if (r < GLYPH_ROWS) begin
              rows[r] <= rows[r] | lts_pkg::row_t'(glyph.rows[r]);
            end
          end
          cols_left <= glyph.width;
          state     <= ST_SHIFT;
        end
        ST_SHIFT: begin
          if (slot_free) begin
            // shared shift step: every row moves one column left
            for (int r = 0; r < lts_pkg::NUM_ROWS; r++) begin
              rows[r] <= {rows[r][lts_pkg::ROW_BITS-2:0], 1'b0};
            end
            last_step <= (cols_left == lts_pkg::width_t'(1));
            cols_left <= cols_left - lts_pkg::width_t'(1);
            if (cols_left == lts_pkg::width_t'(1)) begin
              state <= ST_IDLE;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // column counter never runs dry while shifting
  `LTS_ASSERT_IMPL(a_cols_in_shift, state == ST_SHIFT, cols_left != '0, "shift with no columns left")
  // a dropped code never starts a character
  `LTS_ASSERT_NEXT(a_drop_code, char_take && !code_ok, state == ST_IDLE, "dropped code started work")
  // a column that is not the last keeps the sequencer shifting
  `LTS_ASSERT_IMPL(a_mid_column, pix_valid && !last_step, state == ST_SHIFT, "mid column outside shift")
  // the glyph merge always leads straight into shifting
  `LTS_ASSERT_NEXT(a_load_to_shift, state == ST_LOAD, state == ST_SHIFT, "load not followed by shift")

endmodule

[verif/testbench.sv]
// ---------------------------------------------------------------------------
// testbench
// self-checking bench for the led text scroller unit
// ---------------------------------------------------------------------------
// Character codes go in on the char channel and scroll frames come back on
// the pix channel. A local copy of the row shift registers and its own font
// table predict every frame. A short directed table runs first. Then come
// random characters with random idling on both sides, one long hold-off on
// the pix side that backs the block up, and a final stretch with no idling.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

  localparam int CYCLE_LIMIT  = 250_000;  // watchdog limit for the whole run
  localparam int DRAW_TARGET  = 400;      // drawn characters in the random part
  localparam int LONG_HOLD    = 400;      // cycles of the one long pix hold-off
  localparam int DRAIN_CYCLES = 20;       // extra wait after the owed frames, for strays
  localparam int DIR_ROWS     = 25;
  localparam int MAX_REPORTS  = 10;

  // one scroll frame as seen on the pix channel
  typedef struct packed {
    logic [lts_pkg::NUM_ROWS-1:0][31:0] rows;
    logic                               last;
  } frame_t;

  // how the frames of one accepted character are to be expected
  typedef struct {
    bit          typed;      // frames typed in by hand, not from the predictor
    int unsigned n_frames;
    logic [31:0] first_win;  // every row shows first_win << step
  } char_note_t;

  typedef struct {
    logic [7:0]  code;
    bit          typed;
    int unsigned n_frames;
    logic [31:0] first_win;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        char_valid;
  logic        char_stall;
  logic [7:0]  char_code;
  logic        pix_valid;
  logic        pix_stall;
  logic [31:0] row0_pixels;
  logic [31:0] row1_pixels;
  logic [31:0] row2_pixels;
  logic [31:0] row3_pixels;
  logic [31:0] row4_pixels;
  logic [31:0] row5_pixels;
  logic [31:0] row6_pixels;
  logic        last_step;

  // predictor state: our own copy of the seven row shift registers
  lts_pkg::row_t shift_rows [lts_pkg::NUM_ROWS];

  frame_t      expected_frames [$];  // frames still owed by the block
  frame_t      fresh_frames [$];     // frames of the character just predicted
  char_note_t  char_notes [$];       // one per offered character, in order

  dir_row_t    dir_table [DIR_ROWS];

  int unsigned cycle_count   = 0;
  int unsigned err_count     = 0;
  int unsigned chars_taken   = 0;
  int unsigned codes_dropped = 0;
  int unsigned frames_seen   = 0;

  // idling knobs, set by the main sequence per phase
  int unsigned gap_pct   = 0;
  int unsigned stall_pct = 0;
  bit          hold_request = 1'b0;

  led_text_scroller_unit dut (
    .clk         (clk),
    .rst         (rst),
    .char_valid  (char_valid),
    .char_stall  (char_stall),
    .char_code   (char_code),
    .pix_valid   (pix_valid),
    .pix_stall   (pix_stall),
    .row0_pixels (row0_pixels),
    .row1_pixels (row1_pixels),
    .row2_pixels (row2_pixels),
    .row3_pixels (row3_pixels),
    .row4_pixels (row4_pixels),
    .row5_pixels (row5_pixels),
    .row6_pixels (row6_pixels),
    .last_step   (last_step)
  );

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // font table: {row0, row1, .. row6, width}, row bytes keep pixels in
  // bits 7..3 with the leftmost pixel in bit 7
  function automatic logic [63:0] glyph_bits(input logic [6:0] idx);
    case (idx)
      7'd0:    return 64'h00000000_00000006;
      7'd1:    return 64'h80808080_00008002;
      7'd2:    return 64'hA0A0A000_00000004;
      7'd3:    return 64'h5050F850_F8505006;
      7'd4:    return 64'h2078A070_28F02006;
      7'd5:    return 64'hC0C81020_40981806;
      7'd6:    return 64'h6090A040_A8906806;
      7'd7:    return 64'hC0408000_00000003;
      7'd8:    return 64'h20408080_80402004;
      7'd9:    return 64'h80402020_20408004;
      7'd10:   return 64'h0020A870_A8200006;
      7'd11:   return 64'h002020F8_20200006;
      7'd12:   return 64'h00000000_C0408003;
      7'd13:   return 64'h0000F800_00000006;
      7'd14:   return 64'h00000000_00C0C003;
      7'd15:   return 64'h00081020_40800006;
      7'd16:   return 64'h708898A8_C8887006;
      7'd17:   return 64'h40C04040_4040E004;
      7'd18:   return 64'h70880810_2040F806;
      7'd19:   return 64'hF8102010_08887006;
      7'd20:   return 64'h10305090_F8101006;
      7'd21:   return 64'hF880F008_08887006;
      7'd22:   return 64'h304080F0_88887006;
      7'd23:   return 64'hF8880810_20202006;
      7'd24:   return 64'h70888870_88887006;
      7'd25:   return 64'h70888878_08106006;
      7'd26:   return 64'h00C0C000_C0C00003;
      7'd27:   return 64'h00C0C000_C0408003;
      7'd28:   return 64'h10204080_40201005;
      7'd29:   return 64'h0000F800_F8000006;
      7'd30:   return 64'h80402010_20408005;
      7'd31:   return 64'h70880810_20002006;
      7'd32:   return 64'h70880868_A8A87006;
      7'd33:   return 64'h70888888_F8888806;
      7'd34:   return 64'hF08888F0_8888F006;
      7'd35:   return 64'h70888080_80887006;
      7'd36:   return 64'hE0908888_8890E006;
      7'd37:   return 64'hF88080F0_8080F806;
      7'd38:   return 64'hF88080F0_80808006;
      7'd39:   return 64'h708880B8_88887806;
      7'd40:   return 64'h888888F8_88888806;
      7'd41:   return 64'hE0404040_4040E004;
      7'd42:   return 64'h38101010_10906006;
      7'd43:   return 64'h8890A0C0_A0908806;
      7'd44:   return 64'h80808080_8080F806;
      7'd45:   return 64'h88D8A8A8_88888806;
      7'd46:   return 64'h8888C8A8_98888806;
      7'd47:   return 64'h70888888_88887006;
      7'd48:   return 64'hF08888F0_80808006;
      7'd49:   return 64'h70888888_A8906806;
      7'd50:   return 64'hF08888F0_A0908806;
      7'd51:   return 64'h78808070_0808F006;
      7'd52:   return 64'hF8202020_20202006;
      7'd53:   return 64'h88888888_88887006;
      7'd54:   return 64'h88888888_88502006;
      7'd55:   return 64'h888888A8_A8A85006;
      7'd56:   return 64'h88885020_50888806;
      7'd57:   return 64'h88888850_20202006;
      7'd58:   return 64'hF8081020_4080F806;
      7'd59:   return 64'hE0808080_8080E004;
      7'd60:   return 64'h00804020_10080006;
      7'd61:   return 64'hE0202020_2020E004;
      7'd62:   return 64'h20508800_00000006;
      7'd63:   return 64'h00000000_0000F806;
      7'd64:   return 64'h80402000_00000004;
      7'd65:   return 64'h00007008_78887806;
      7'd66:   return 64'h8080B0C8_8888F006;
      7'd67:   return 64'h00007088_80887006;
      7'd68:   return 64'h08086898_88887806;
      7'd69:   return 64'h00007088_F8807006;
      7'd70:   return 64'h304840E0_40404006;
      7'd71:   return 64'h00788888_78087006;
      7'd72:   return 64'h8080B0C8_88888806;
      7'd73:   return 64'h4000C040_4040E004;
      7'd74:   return 64'h10003010_10906005;
      7'd75:   return 64'h808090A0_C0A09005;
      7'd76:   return 64'hC0404040_4040E004;
      7'd77:   return 64'h0000D0A8_A8888806;
      7'd78:   return 64'h0000B0C8_88888806;
      7'd79:   return 64'h00007088_88887006;
      7'd80:   return 64'h0000F088_F0808006;
      7'd81:   return 64'h00006898_78080806;
      7'd82:   return 64'h0000B0C8_80808006;
      7'd83:   return 64'h00007080_7008F006;
      7'd84:   return 64'h4040E040_40483006;
      7'd85:   return 64'h00008888_88986806;
      7'd86:   return 64'h00008888_88502006;
      7'd87:   return 64'h000088A8_A8A85006;
      7'd88:   return 64'h00008850_20508806;
      7'd89:   return 64'h00008888_78087006;
      7'd90:   return 64'h0000F810_2040F806;
      7'd91:   return 64'h20404080_40402004;
      7'd92:   return 64'h80808080_80808002;
      7'd93:   return 64'h80404020_40408004;
      7'd94:   return 64'h00000068_90000006;
      7'd95:   return 64'h60909060_00000005;
      default: return 64'h0;
    endcase
  endfunction

  // merge one glyph into the local rows and scroll it in, one frame per column
  function automatic void scroll_glyph(input logic [7:0] code);
    logic [63:0] g;
    int unsigned cols;
    frame_t      f;
    if (code < lts_pkg::FIRST_CODE || code > lts_pkg::LAST_CODE) return;
    g = glyph_bits(7'(code - lts_pkg::FIRST_CODE));
    for (int r = 0; r < lts_pkg::NUM_ROWS; r++) begin
      if (r < lts_pkg::GLYPH_ROWS) begin
        shift_rows[r] = shift_rows[r] | lts_pkg::row_t'(g[63-8*r -: 8]);
      end
    end
    cols = 32'(g[7:0]);
    if (cols > lts_pkg::MAX_WIDTH) cols = lts_pkg::MAX_WIDTH;
    for (int s = 0; s < cols; s++) begin
      for (int r = 0; r < lts_pkg::NUM_ROWS; r++) begin
        // bits pushed past the top of a row are lost
        shift_rows[r] = {shift_rows[r][lts_pkg::ROW_BITS-2:0], 1'b0};
        f.rows[r] = shift_rows[r][lts_pkg::ROW_BITS-1:lts_pkg::WIN_LSB];
      end
      f.last = (s == cols - 1);
      fresh_frames.push_back(f);
    end
  endfunction

  // offer one character and hold it until the block takes it
  task automatic offer_char(input logic [7:0] code, input bit typed,
                            input int unsigned n_frames, input logic [31:0] first_win);
    char_note_t note;
    note.typed     = typed;
    note.n_frames  = n_frames;
    note.first_win = first_win;
    char_notes.push_back(note);
    char_valid <= 1'b1;
    char_code  <= code;
    // stall sampled at the edge is the value from the cycle before it
    do @(posedge clk); while (char_stall);
  endtask

  // random gap after an accepted item, valid stays high when there is none
  task automatic char_gap();
    if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      char_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
  endtask

  // mostly printable codes, some codes that are simply dropped
  function automatic logic [7:0] pick_code();
    if ($urandom_range(0, 99) < 12) begin
      if ($urandom_range(0, 1)) return 8'($urandom_range(0, 31));
      return 8'($urandom_range(128, 255));
    end
    return 8'($urandom_range(32, 127));
  endfunction

  // predict at every accepted char item
  always @(posedge clk) begin
    char_note_t note;
    frame_t     f;
    if (!rst && char_valid && !char_stall) begin
      note = char_notes.pop_front();
      chars_taken++;
      if (char_code < lts_pkg::FIRST_CODE || char_code > lts_pkg::LAST_CODE) codes_dropped++;
      scroll_glyph(char_code);
      if (note.typed) begin
        // hand-typed frames replace the predicted ones, state still advances
        fresh_frames.delete();
        for (int s = 0; s < note.n_frames; s++) begin
          for (int r = 0; r < lts_pkg::NUM_ROWS; r++) f.rows[r] = note.first_win << s;
          f.last = (s == note.n_frames - 1);
          expected_frames.push_back(f);
        end
      end else begin
        while (fresh_frames.size() > 0) expected_frames.push_back(fresh_frames.pop_front());
      end
    end
  end

  // check every accepted pix item against the oldest expected frame
  always @(posedge clk) begin
    frame_t got;
    frame_t want;
    bit     bad;
    if (!rst && pix_valid && !pix_stall) begin
      frames_seen++;
      got.rows[0] = row0_pixels;
      got.rows[1] = row1_pixels;
      got.rows[2] = row2_pixels;
      got.rows[3] = row3_pixels;
      got.rows[4] = row4_pixels;
      got.rows[5] = row5_pixels;
      got.rows[6] = row6_pixels;
      got.last    = last_step;
      if (expected_frames.size() == 0) begin
        err_count++;
        if (err_count <= MAX_REPORTS)
          $display("frame %0d: none expected, got %h", frames_seen, got);
      end else begin
        want = expected_frames.pop_front();
        bad  = (got.last !== want.last);
        for (int r = 0; r < lts_pkg::NUM_ROWS; r++) begin
          if (got.rows[r] !== want.rows[r]) bad = 1'b1;
        end
        if (bad) begin
          err_count++;
          if (err_count <= MAX_REPORTS)
            $display("frame %0d mismatch: expected %h actual %h", frames_seen, want, got);
        end
      end
    end
  end

  // pix side idling, plus the one long hold-off counted here in cycles
  initial begin
    pix_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        pix_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        pix_stall <= 1'b0;
      end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
        pix_stall <= 1'b1;
        repeat ($urandom_range(1, 15)) @(posedge clk);
        pix_stall <= 1'b0;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    int unsigned drawn;
    int unsigned waited;
    logic [7:0]  code;

    rst        <= 1'b1;
    char_valid <= 1'b0;
    char_code  <= 8'h00;
    for (int r = 0; r < lts_pkg::NUM_ROWS; r++) shift_rows[r] = '0;

    // directed table: typed rows are plain enough to write down by hand,
    // the rest go through the predictor
    dir_table = '{
      '{8'h00, 1'b1, 0, 32'h0},  // lowest code, dropped
      '{8'h20, 1'b1, 6, 32'h0},  // blank glyph on cleared rows, six empty frames
      '{8'h7C, 1'b1, 2, 32'h1},  // bar: one pixel per row walks into the window
      '{8'h1F, 1'b1, 0, 32'h0},  // just below the font
      '{8'h80, 1'b1, 0, 32'h0},  // just above the font
      '{8'hFF, 1'b1, 0, 32'h0},  // highest code, dropped
      '{8'h7F, 1'b0, 0, 32'h0},  // last glyph
      '{8'h21, 1'b0, 0, 32'h0},  // width 2
      '{8'h7E, 1'b0, 0, 32'h0},
      '{8'h22, 1'b0, 0, 32'h0},  // width 4
      '{8'h27, 1'b0, 0, 32'h0},  // width 3
      '{8'h3C, 1'b0, 0, 32'h0},  // width 5
      '{8'h41, 1'b0, 0, 32'h0},
      '{8'h57, 1'b0, 0, 32'h0},
      '{8'h5A, 1'b0, 0, 32'h0},
      '{8'h61, 1'b0, 0, 32'h0},
      '{8'h7A, 1'b0, 0, 32'h0},
      '{8'h40, 1'b0, 0, 32'h0},
      '{8'h6A, 1'b0, 0, 32'h0},
      '{8'h23, 1'b0, 0, 32'h0},  // dense glyph, low byte leftovers scroll up
      '{8'h23, 1'b0, 0, 32'h0},
      '{8'h30, 1'b0, 0, 32'h0},
      '{8'h7D, 1'b0, 0, 32'h0},
      '{8'h5F, 1'b0, 0, 32'h0},
      '{8'h55, 1'b0, 0, 32'h0}
    };

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    gap_pct   = 25;
    stall_pct = 10;
    for (int i = 0; i < DIR_ROWS; i++) begin
      offer_char(dir_table[i].code, dir_table[i].typed,
                 dir_table[i].n_frames, dir_table[i].first_win);
      char_gap();
    end

    // random part, phases by number of drawn characters
    drawn = 0;
    while (drawn < DRAW_TARGET) begin
      if (drawn < 150) begin
        gap_pct   = 30;
        stall_pct = 12;
      end else if (drawn < 240) begin
        // back-to-back items while the pix side holds off for a long time
        gap_pct   = 0;
        stall_pct = 5;
        if (drawn == 150) hold_request = 1'b1;
      end else if (drawn < DRAW_TARGET - 80) begin
        gap_pct   = 15;
        stall_pct = 6;
      end else begin
        // closing stretch with no idling on either side
        gap_pct   = 0;
        stall_pct = 0;
      end
      code = pick_code();
      if (code >= lts_pkg::FIRST_CODE && code <= lts_pkg::LAST_CODE) drawn++;
      offer_char(code, 1'b0, 0, 32'h0);
      char_gap();
    end
    char_valid <= 1'b0;

    // let every owed frame arrive, then wait DRAIN_CYCLES longer for strays
    waited = 0;
    while (expected_frames.size() > 0 && waited < CYCLE_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_frames.size() > 0) begin
      err_count++;
      $display("%0d expected frames never arrived", expected_frames.size());
    end

    $display("covered %0d characters (%0d dropped codes), %0d frames checked",
             chars_taken, codes_dropped, frames_seen);
    $display("idling on both sides, one %0d-cycle pix hold-off, %0d mismatches",
             LONG_HOLD, err_count);
    if (err_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

[led_text_scroller_unit.f]
+incdir+src
src/lts_pkg.sv
src/led_text_scroller_unit.sv
verif/testbench.sv
